>>> sv/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg: shared types and constants of the SHA-1 hash engine
// Word types, command codes, initial vector, round constants, round control.
// ----------------------------------------------------------------------------
package sha1_pkg;

	typedef logic [31:0]      word_t;
	typedef logic [4:0][31:0] wvec5_t;
	typedef logic [3:0][31:0] kvec_t;

	localparam logic [1:0] CMD_DATA    = 2'd0;
	localparam logic [1:0] CMD_FINISH  = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	localparam int unsigned SCHED_CELLS  = 16;
	localparam int unsigned DIGEST_WORDS = 5;

	// Index 0 is the first word (A .. E)
	localparam wvec5_t SHA1_IV = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	localparam kvec_t SHA1_K = {
		32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef struct packed {
		logic       load;   // take the chaining value into A .. E
		logic       step;   // run one round
		logic [1:0] phase;  // round group of twenty
	} round_ctl_t;

endpackage

>>> sv/sha1_wcell.sv
// ----------------------------------------------------------------------------
// sha1_wcell: one word cell of the message schedule chain
// Holds one 32-bit schedule word; loads a block word or takes its neighbor's.
// ----------------------------------------------------------------------------
module sha1_wcell (
	input  logic            clk,
	input  logic            load,
	input  logic            shift,
	input  sha1_pkg::word_t ld_word,
	input  sha1_pkg::word_t sh_word,
	output sha1_pkg::word_t q
);
	import sha1_pkg::*;

	word_t word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= ld_word;
		end else if (shift) begin
			word_q <= sh_word;
		end
	end

	assign q = word_q;

endmodule

>>> sv/sha1_round.sv
// ----------------------------------------------------------------------------
// sha1_round: SHA-1 round unit
// Working variables A .. E and one compression round per step.
// ----------------------------------------------------------------------------
module sha1_round (
	input  logic                 clk,
	input  sha1_pkg::round_ctl_t ctl,
	input  sha1_pkg::wvec5_t     chain,
	input  sha1_pkg::word_t      w,
	output sha1_pkg::wvec5_t     vars
);
	import sha1_pkg::*;

	word_t a_q, b_q, c_q, d_q, e_q;
	word_t f;
	word_t t;

	always_comb begin
		unique case (ctl.phase)
			2'd0:       f = (b_q & c_q) | (~b_q & d_q);
			2'd2:       f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			2'd1, 2'd3: f = b_q ^ c_q ^ d_q;
		endcase
		t = {a_q[26:0], a_q[31:27]} + f + e_q + w + SHA1_K[ctl.phase];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= chain[0];
			b_q <= chain[1];
			c_q <= chain[2];
			d_q <= chain[3];
			e_q <= chain[4];
		end else if (ctl.step) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
		end
	end

	assign vars = {e_q, d_q, c_q, b_q, a_q};

endmodule

>>> sv/sha1_hash_engine.sv
// A data byte is taken while idle; the byte that fills a block stalls input
// through load, the rounds of the schedule chain and the chaining add.
// Finish: one or two blocks of compression, then one digest word per cycle while out_stall allows.
// A block costs 64 byte beats plus the compression stall, in which no byte is taken.
// Reset: control clears at once, chaining value to the initial vector, counters to
// zero; the block buffer holds no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
// sha1_hash_engine: SHA-1 hasher, top level
// Byte-wide message input, padding, 80-round compression over a 16-cell
// schedule chain, and a registered digest output of five word beats.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);
	import sha1_pkg::*;

	// Sequencer: take beats in idle, then load / rounds / chaining add,
	// then emit five digest beats after a finish.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOAD  = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_UPD   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t     state_q;
	wvec5_t     h_q;
	word_t      buf_q [SCHED_CELLS];
	logic [5:0] fill_q;
	logic [63:0] len_q;
	logic       fin_q;   // current compression belongs to a finish
	logic       more_q;  // current block is the first of two padded blocks
	logic [4:0] cnt_q;   // round within its group of twenty
	logic [1:0] phase_q; // group of twenty
	logic [2:0] idx_q;   // next digest word to emit

	logic        out_valid_q;
	word_t       digest_word_q;
	logic [2:0]  word_index_q;
	logic        last_q;

	logic        in_acc;
	logic        out_load;
	logic        first_two;
	logic        two_blk;
	word_t       blk_first [SCHED_CELLS];
	word_t       blk_last  [SCHED_CELLS];
	word_t       ld_blk    [SCHED_CELLS];
	word_t       cell_q    [SCHED_CELLS];
	word_t       cell_in   [SCHED_CELLS];
	word_t       fb;
	wvec5_t      vars;
	round_ctl_t  rctl;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = !out_valid_q || !out_stall;

	// A message whose tail leaves no room for the length needs two blocks
	assign two_blk   = (fill_q >= 6'd56);
	assign first_two = fin_q && two_blk && !more_q;

	// Padded block images, built byte by byte from the buffer, the fill
	// position and the big-endian bit length.
	always_comb begin
		logic [7:0] old_b;
		logic [7:0] len_b;
		logic [7:0] fst_b;
		logic [7:0] lst_b;
		for (int p = 0; p < 64; p++) begin
			old_b = buf_q[p / 4][31 - 8 * (p % 4) -: 8];
			len_b = len_q[8 * ((63 - p) % 8) +: 8];
			if (6'(p) < fill_q) begin
				fst_b = old_b;
			end else if (6'(p) == fill_q) begin
				fst_b = PAD_BYTE;
			end else begin
				fst_b = 8'h00;
			end
			if (p >= 56) begin
				lst_b = len_b;
			end else if (two_blk) begin
				lst_b = 8'h00;
			end else begin
				lst_b = fst_b;
			end
			blk_first[p / 4][31 - 8 * (p % 4) -: 8] = fst_b;
			blk_last[p / 4][31 - 8 * (p % 4) -: 8]  = lst_b;
		end
	end

	always_comb begin
		for (int i = 0; i < SCHED_CELLS; i++) begin
			if (!fin_q) begin
				ld_blk[i] = buf_q[i];
			end else if (first_two) begin
				ld_blk[i] = blk_first[i];
			end else begin
				ld_blk[i] = blk_last[i];
			end
		end
	end

	// Schedule chain: each cell hands its word to the left every round,
	// the rightmost cell takes the new expanded word.
	assign fb = cell_q[13] ^ cell_q[8] ^ cell_q[2] ^ cell_q[0];

	always_comb begin
		for (int i = 0; i < SCHED_CELLS - 1; i++) begin
			cell_in[i] = cell_q[i + 1];
		end
		cell_in[SCHED_CELLS - 1] = {fb[30:0], fb[31]};
	end

	for (genvar g = 0; g < SCHED_CELLS; g++) begin : g_cell
		sha1_wcell u_cell (
			.clk     (clk),
			.load    (state_q == ST_LOAD),
			.shift   (state_q == ST_ROUND),
			.ld_word (ld_blk[g]),
			.sh_word (cell_in[g]),
			.q       (cell_q[g])
		);
	end

	assign rctl.load  = (state_q == ST_LOAD);
	assign rctl.step  = (state_q == ST_ROUND);
	assign rctl.phase = phase_q;

	sha1_round u_round (
		.clk   (clk),
		.ctl   (rctl),
		.chain (h_q),
		.w     (cell_q[0]),
		.vars  (vars)
	);

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h_q         <= SHA1_IV;
			fill_q      <= '0;
			len_q       <= '0;
			fin_q       <= 1'b0;
			more_q      <= 1'b0;
			cnt_q       <= '0;
			phase_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid when a digest word is loaded, drop it once taken
			if (state_q == ST_EMIT && out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						priority if (cmd == CMD_DATA) begin
							fill_q <= fill_q + 6'd1;
							len_q  <= len_q + 64'd8;
							fin_q  <= 1'b0;
							if (fill_q == 6'd63) begin
								state_q <= ST_LOAD;
							end
						end else if (cmd == CMD_FINISH) begin
							fin_q   <= 1'b1;
							more_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else if (cmd == CMD_RESTART) begin
							h_q    <= SHA1_IV;
							fill_q <= '0;
							len_q  <= '0;
						end else begin
							// drop the unused command code
						end
					end
				end
				ST_LOAD: begin
					more_q  <= first_two;
					cnt_q   <= '0;
					phase_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (cnt_q == 5'd19) begin
						cnt_q   <= '0;
						phase_q <= phase_q + 2'd1;
						if (phase_q == 2'd3) begin
							state_q <= ST_UPD;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_UPD: begin
					for (int i = 0; i < DIGEST_WORDS; i++) begin
						h_q[i] <= h_q[i] + vars[i];
					end
					if (fin_q && more_q) begin
						state_q <= ST_LOAD;
					end else if (fin_q) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'(DIGEST_WORDS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

	// Block buffer: byte writes in idle, last padded block written back on finish
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && cmd == CMD_DATA) begin
			buf_q[fill_q[5:2]][31 - 8 * fill_q[1:0] -: 8] <= data_byte;
		end else if (state_q == ST_LOAD && fin_q && !first_two) begin
			buf_q <= blk_last;
		end
	end

	// Output register: advance only when the beat slot is free
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_load) begin
			digest_word_q <= h_q[idx_q];
			word_index_q  <= idx_q;
			last_q        <= (idx_q == 3'(DIGEST_WORDS - 1));
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = digest_word_q;
	assign word_index  = word_index_q;
	assign last        = last_q;

endmodule

>>> sv/sha1_check.sv
// ----------------------------------------------------------------------------
// sha1_check: port checker for the SHA-1 hash engine
// Watches handshakes and digest beats on the top-level ports.
// ----------------------------------------------------------------------------
module sha1_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  cmd,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last
);
	import sha1_pkg::*;

	a_last_index : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (word_index == 3'd4)))
		else $error("last beat does not match word index");

	a_finish_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && cmd == CMD_FINISH) |=> in_stall)
		else $error("input not held after finish");

	a_restart_quick : assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && cmd == CMD_RESTART) |=> !in_stall)
		else $error("restart did not complete in one cycle");

	a_out_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(digest_word) && $stable(word_index)))
		else $error("stalled digest beat changed");

endmodule

bind sha1_hash_engine sha1_check u_sha1_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.cmd         (cmd),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.digest_word (digest_word),
	.word_index  (word_index),
	.last        (last)
);
